@@ rtl/cpot_pkg.sv @@
// Shared types and constants for the convex polygon overlap test.
// Holds the item structs, the opcodes, the status codes and the sequencer states.
// No dependencies.
package cpot_pkg;

  localparam int unsigned MaxVerticesDef = 16;
  localparam int unsigned CoordBits      = 16;
  localparam int unsigned AxisBits       = CoordBits + 1;
  localparam int unsigned ProdBits       = CoordBits + AxisBits;
  localparam int unsigned DotBits        = ProdBits + 1;

  typedef enum logic [1:0] {
    OP_LOAD1 = 2'd0,
    OP_LOAD2 = 2'd1,
    OP_TEST  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } stat_e;

  typedef struct packed {
    op_e                         operation;
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
  } in_t;

  typedef struct packed {
    logic  collision;
    stat_e status;
  } out_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } vertex_t;

  typedef enum logic [2:0] {
    PU_NOP,
    PU_V0,
    PU_AXIS,
    PU_MULX,
    PU_MULY,
    PU_ACC
  } pu_op_e;

  typedef struct packed {
    pu_op_e op;
    logic   first;
    logic   sel;
  } pu_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E0,
    ST_E1,
    ST_AX,
    ST_MX,
    ST_MY,
    ST_ACC,
    ST_GAP,
    ST_DONE
  } state_e;

endpackage

@@ rtl/cpot_store.sv @@
// Vertex store: one write port, one registered read port.
// Depends on cpot_pkg for the vertex type.
module cpot_store #(
  parameter int unsigned Depth = cpot_pkg::MaxVerticesDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  cpot_pkg::vertex_t        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output cpot_pkg::vertex_t        rdata_o
);

  cpot_pkg::vertex_t mem_q [Depth];
  cpot_pkg::vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cpot_proj.sv @@
// Shared projection unit: edge axis, one multiplier, dot accumulate, min/max, gap test.
// Depends on cpot_pkg for the vertex and command types.
module cpot_proj (
  input  logic              clk_i,
  input  cpot_pkg::pu_cmd_t cmd_i,
  input  cpot_pkg::vertex_t vtx_i,
  output logic              sep_o
);

  localparam int unsigned CB = cpot_pkg::CoordBits;
  localparam int unsigned AB = cpot_pkg::AxisBits;
  localparam int unsigned PB = cpot_pkg::ProdBits;
  localparam int unsigned DB = cpot_pkg::DotBits;

  logic signed [CB-1:0] x0_q, x0_d, y0_q, y0_d;
  logic signed [AB-1:0] ax_q, ax_d, ay_q, ay_d;
  logic signed [PB-1:0] prod_q, prod_d, acc_q, acc_d;
  logic signed [DB-1:0] lo1_q, lo1_d, hi1_q, hi1_d, lo2_q, lo2_d, hi2_q, hi2_d;

  logic signed [CB-1:0] mul_a;
  logic signed [AB-1:0] mul_b;
  logic signed [PB-1:0] mul_p;
  logic signed [DB-1:0] dot;

  assign mul_a = (cmd_i.op == cpot_pkg::PU_MULX) ? vtx_i.x : vtx_i.y;
  assign mul_b = (cmd_i.op == cpot_pkg::PU_MULX) ? ax_q : ay_q;
  assign mul_p = PB'(mul_a) * PB'(mul_b);
  assign dot   = DB'(acc_q) + DB'(prod_q);

  always_comb begin
    x0_d   = x0_q;
    y0_d   = y0_q;
    ax_d   = ax_q;
    ay_d   = ay_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    lo1_d  = lo1_q;
    hi1_d  = hi1_q;
    lo2_d  = lo2_q;
    hi2_d  = hi2_q;
    case (cmd_i.op)
      cpot_pkg::PU_V0: begin
        x0_d = vtx_i.x;
        y0_d = vtx_i.y;
      end
      cpot_pkg::PU_AXIS: begin
        ax_d = AB'(y0_q) - AB'(vtx_i.y);
        ay_d = AB'(vtx_i.x) - AB'(x0_q);
      end
      cpot_pkg::PU_MULX: begin
        prod_d = mul_p;
      end
      cpot_pkg::PU_MULY: begin
        acc_d  = prod_q;
        prod_d = mul_p;
      end
      cpot_pkg::PU_ACC: begin
        if (cmd_i.sel) begin
          if (cmd_i.first || dot < lo2_q) lo2_d = dot;
          if (cmd_i.first || dot > hi2_q) hi2_d = dot;
        end else begin
          if (cmd_i.first || dot < lo1_q) lo1_d = dot;
          if (cmd_i.first || dot > hi1_q) hi1_d = dot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    lo1_q  <= lo1_d;
    hi1_q  <= hi1_d;
    lo2_q  <= lo2_d;
    hi2_q  <= hi2_d;
  end

  assign sep_o = (lo1_q < lo2_q) ? (lo2_q > hi1_q) : (lo1_q > hi2_q);

endmodule

@@ rtl/convex_polygon_overlap_test.sv @@
// Separating axis overlap test of two convex polygons loaded vertex by vertex.
// Vertex load: one load item accepted per cycle while idle. Test item: one multiplier
// pass per coordinate; stops early at the first separating axis; error cases go
// straight to the result. Not ready during a test.
// Reset clears counts, overflow flag, sequencer and output valid; store contents stay.
// Depends on cpot_pkg, cpot_store and cpot_proj.
module convex_polygon_overlap_test #(
  parameter int unsigned MaxVertices = cpot_pkg::MaxVerticesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cpot_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cpot_pkg::out_t out_o
);

  localparam int unsigned AddrBits = $clog2(MaxVertices);
  localparam int unsigned CntBits  = $clog2(MaxVertices + 1);

  cpot_pkg::state_e state_q, state_d;

  logic [CntBits-1:0]  cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic                ovf_q, ovf_d;
  logic [AddrBits-1:0] k_q, k_d, idx_q, idx_d;
  logic                edge_poly_q, edge_poly_d, proj_poly_q, proj_poly_d;
  logic                rd_sel_q, rd_sel_d;
  logic                coll_q, coll_d;
  cpot_pkg::stat_e     stat_q, stat_d;
  logic                out_valid_q, out_valid_d;
  cpot_pkg::out_t      out_q, out_d;

  logic                in_fire, we1, we2, rd_en, sep;
  logic [AddrBits-1:0] rd_addr;
  cpot_pkg::vertex_t   wdata, rdata1, rdata2, vtx;
  cpot_pkg::pu_cmd_t   cmd;
  logic [CntBits-1:0]  k_next, idx_next, n_edge, n_proj;
  logic                last_edge, last_idx;

  assign in_fire = in_valid_i && in_ready_o;
  assign wdata   = '{x: in_i.vertex_x, y: in_i.vertex_y};
  assign we1 = in_fire && (in_i.operation == cpot_pkg::OP_LOAD1)
               && (cnt1_q < CntBits'(MaxVertices));
  assign we2 = in_fire && (in_i.operation == cpot_pkg::OP_LOAD2)
               && (cnt2_q < CntBits'(MaxVertices));

  cpot_store #(.Depth(MaxVertices)) u_store1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (cnt1_q[AddrBits-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  cpot_store #(.Depth(MaxVertices)) u_store2 (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (cnt2_q[AddrBits-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata2)
  );

  assign vtx = rd_sel_q ? rdata2 : rdata1;

  cpot_proj u_proj (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .vtx_i (vtx),
    .sep_o (sep)
  );

  assign k_next    = CntBits'(k_q) + CntBits'(1);
  assign idx_next  = CntBits'(idx_q) + CntBits'(1);
  assign n_edge    = edge_poly_q ? cnt2_q : cnt1_q;
  assign n_proj    = proj_poly_q ? cnt2_q : cnt1_q;
  assign last_edge = (k_next >= n_edge);
  assign last_idx  = (idx_next >= n_proj);

  always_comb begin
    state_d     = state_q;
    cnt1_d      = cnt1_q;
    cnt2_d      = cnt2_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    idx_d       = idx_q;
    edge_poly_d = edge_poly_q;
    proj_poly_d = proj_poly_q;
    rd_sel_d    = rd_sel_q;
    coll_d      = coll_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    cmd         = '{op: cpot_pkg::PU_NOP, first: 1'b0, sel: 1'b0};
    case (state_q)
      cpot_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_i.operation)
            cpot_pkg::OP_LOAD1: begin
              if (we1) cnt1_d = cnt1_q + CntBits'(1);
              else     ovf_d  = 1'b1;
            end
            cpot_pkg::OP_LOAD2: begin
              if (we2) cnt2_d = cnt2_q + CntBits'(1);
              else     ovf_d  = 1'b1;
            end
            cpot_pkg::OP_TEST: begin
              coll_d      = 1'b0;
              edge_poly_d = 1'b0;
              k_d         = '0;
              if (ovf_q) begin
                stat_d  = cpot_pkg::STAT_OVERFLOW;
                state_d = cpot_pkg::ST_DONE;
              end else if (cnt1_q == '0 || cnt2_q == '0) begin
                stat_d  = cpot_pkg::STAT_EMPTY;
                state_d = cpot_pkg::ST_DONE;
              end else begin
                coll_d  = 1'b1;
                stat_d  = cpot_pkg::STAT_OK;
                state_d = cpot_pkg::ST_E0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cpot_pkg::ST_E0: begin
        rd_en    = 1'b1;
        rd_addr  = k_q;
        rd_sel_d = edge_poly_q;
        state_d  = cpot_pkg::ST_E1;
      end
      cpot_pkg::ST_E1: begin
        cmd.op  = cpot_pkg::PU_V0;
        rd_en   = 1'b1;
        rd_addr = last_edge ? '0 : k_next[AddrBits-1:0];
        state_d = cpot_pkg::ST_AX;
      end
      cpot_pkg::ST_AX: begin
        cmd.op      = cpot_pkg::PU_AXIS;
        rd_en       = 1'b1;
        rd_addr     = '0;
        rd_sel_d    = 1'b0;
        proj_poly_d = 1'b0;
        idx_d       = '0;
        state_d     = cpot_pkg::ST_MX;
      end
      cpot_pkg::ST_MX: begin
        cmd.op  = cpot_pkg::PU_MULX;
        state_d = cpot_pkg::ST_MY;
      end
      cpot_pkg::ST_MY: begin
        cmd.op  = cpot_pkg::PU_MULY;
        state_d = cpot_pkg::ST_ACC;
      end
      cpot_pkg::ST_ACC: begin
        cmd = '{op: cpot_pkg::PU_ACC, first: (idx_q == '0), sel: proj_poly_q};
        if (!last_idx) begin
          rd_en   = 1'b1;
          rd_addr = idx_next[AddrBits-1:0];
          idx_d   = idx_next[AddrBits-1:0];
          state_d = cpot_pkg::ST_MX;
        end else if (!proj_poly_q) begin
          rd_en       = 1'b1;
          rd_addr     = '0;
          rd_sel_d    = 1'b1;
          proj_poly_d = 1'b1;
          idx_d       = '0;
          state_d     = cpot_pkg::ST_MX;
        end else begin
          state_d = cpot_pkg::ST_GAP;
        end
      end
      cpot_pkg::ST_GAP: begin
        if (sep) begin
          coll_d  = 1'b0;
          state_d = cpot_pkg::ST_DONE;
        end else if (!last_edge) begin
          k_d     = k_next[AddrBits-1:0];
          state_d = cpot_pkg::ST_E0;
        end else if (!edge_poly_q) begin
          edge_poly_d = 1'b1;
          k_d         = '0;
          state_d     = cpot_pkg::ST_E0;
        end else begin
          state_d = cpot_pkg::ST_DONE;
        end
      end
      cpot_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '{collision: coll_q, status: stat_q};
          cnt1_d      = '0;
          cnt2_d      = '0;
          ovf_d       = 1'b0;
          state_d     = cpot_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpot_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpot_pkg::ST_IDLE;
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt1_q      <= cnt1_d;
      cnt2_q      <= cnt2_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    idx_q       <= idx_d;
    edge_poly_q <= edge_poly_d;
    proj_poly_q <= proj_poly_d;
    rd_sel_q    <= rd_sel_d;
    coll_q      <= coll_d;
    stat_q      <= stat_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt1_q <= CntBits'(MaxVertices)) && (cnt2_q <= CntBits'(MaxVertices)))
    else $error("vertex count beyond store depth");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpot_pkg::ST_E0) |-> (cnt1_q != '0) && (cnt2_q != '0) && !ovf_q)
    else $error("edge walk started on empty or overflowed polygons");

  a_counts_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpot_pkg::ST_MX) |=> $stable(cnt1_q) && $stable(cnt2_q))
    else $error("vertex count changed during a test");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpot_pkg::ST_DONE && (!out_valid_q || out_ready_i))
    |=> (cnt1_q == '0) && (cnt2_q == '0) && !ovf_q && out_valid_q)
    else $error("stores not cleared after a result");

  a_error_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != cpot_pkg::STAT_OK) |-> !out_q.collision)
    else $error("collision reported with an error status");

endmodule
